[hdl/bistable_actuator_pulse_fsm_assert.svh]
// Assertion macros for the shutter coil controller.
`ifndef BISTABLE_ACTUATOR_PULSE_FSM_ASSERT_SVH
`define BISTABLE_ACTUATOR_PULSE_FSM_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BAPF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define BAPF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/bapf_pkg.sv]
// Types and constants for the shutter coil controller.
`default_nettype none

package bapf_pkg;

  localparam int TIME_BITS = 32;
  localparam int VOLT_BITS = 16;
  localparam int CFG_BITS  = 16;

  localparam logic [1:0] REQ_POLL  = 2'd0;
  localparam logic [1:0] REQ_OPEN  = 2'd1;
  localparam logic [1:0] REQ_CLOSE = 2'd2;

  localparam logic [1:0] CFG_PULSE_TIME   = 2'd0;
  localparam logic [1:0] CFG_WAIT_TIME    = 2'd1;
  localparam logic [1:0] CFG_MIN_VOLTAGE  = 2'd2;
  localparam logic [1:0] CFG_WORK_VOLTAGE = 2'd3;

  localparam logic [CFG_BITS-1:0] PULSE_TIME_RST   = 16'd50;
  localparam logic [CFG_BITS-1:0] WAIT_TIME_RST    = 16'd100;
  localparam logic [CFG_BITS-1:0] MIN_VOLTAGE_RST  = 16'd8000;
  localparam logic [CFG_BITS-1:0] WORK_VOLTAGE_RST = 16'd10000;

  typedef enum logic [1:0] {
    ST_ERROR   = 2'd0,
    ST_RELAX   = 2'd1,
    ST_PROCESS = 2'd2,
    ST_WAIT    = 2'd3
  } state_t;

  typedef enum logic [1:0] {
    DRV_OFF   = 2'd0,
    DRV_OPEN  = 2'd1,
    DRV_CLOSE = 2'd2,
    DRV_HIZ   = 2'd3
  } drive_t;

  typedef struct packed {
    logic [1:0]           req_type;
    logic [TIME_BITS-1:0] now_ms;
    logic [VOLT_BITS-1:0] supply_voltage;
    logic                 hall_open;
    logic                 driver_fault;
    logic                 button_level;
  } in_item_t;

  typedef struct packed {
    logic [1:0] drive_mode;
    logic [1:0] ctrl_state;
    logic       cmd_accepted;
    logic       position_report;
    logic       position_open;
  } out_item_t;

endpackage

`default_nettype wire

[hdl/bistable_actuator_pulse_fsm.sv]
// Top level: bistable shutter coil pulse controller.
// Takes one poll or open/close command item per clock and returns one result item
// for each. The item is registered on entry; the controller state is updated and
// the result registered as the item leaves the input register. Sustained rate is
// one item per cycle, limited only by the result register being taken; in_stall
// rises only when both registers hold items and out_stall is high. Configuration
// writes take effect on the next clock.
`default_nettype none

module bistable_actuator_pulse_fsm
  import bapf_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire in_item_t            in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output out_item_t                out_data,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [CFG_BITS-1:0] cfg_data
);

  `include "bistable_actuator_pulse_fsm_assert.svh"

  logic [CFG_BITS-1:0]  pulse_time_r;
  logic [CFG_BITS-1:0]  wait_time_r;
  logic [CFG_BITS-1:0]  min_voltage_r;
  logic [CFG_BITS-1:0]  work_voltage_r;

  logic                 s1_valid_r;
  in_item_t             s1_data_r;
  logic                 out_valid_r;
  out_item_t            out_data_r;

  state_t               state_r, state_nxt;
  drive_t               drive_r, drive_nxt;
  logic [TIME_BITS-1:0] phase_r, phase_nxt;
  logic                 last_button_r, last_button_nxt;

  logic                 out_free;
  logic                 s1_fire;
  logic                 is_cmd;
  logic                 want_open;
  logic                 volt_work_ok;
  logic                 volt_min_low;
  logic [TIME_BITS-1:0] elapsed;
  logic                 pulse_over;
  logic                 wait_over;
  out_item_t            result;

  assign out_free  = !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign is_cmd       = (s1_data_r.req_type == REQ_OPEN) || (s1_data_r.req_type == REQ_CLOSE);
  assign want_open    = (s1_data_r.req_type == REQ_OPEN);
  assign volt_work_ok = (s1_data_r.supply_voltage >= work_voltage_r);
  assign volt_min_low = (s1_data_r.supply_voltage < min_voltage_r);
  assign elapsed      = s1_data_r.now_ms - phase_r;
  assign pulse_over   = elapsed > {{(TIME_BITS-CFG_BITS){1'b0}}, pulse_time_r};
  assign wait_over    = elapsed > {{(TIME_BITS-CFG_BITS){1'b0}}, wait_time_r};

  // Next state
  always_comb begin
    state_nxt       = state_r;
    drive_nxt       = drive_r;
    phase_nxt       = phase_r;
    last_button_nxt = last_button_r;
    if (is_cmd) begin
      if (want_open != s1_data_r.hall_open && volt_work_ok && state_r != ST_ERROR) begin
        drive_nxt = want_open ? DRV_OPEN : DRV_CLOSE;
        state_nxt = ST_PROCESS;
        phase_nxt = s1_data_r.now_ms;
      end
    end else begin
      unique case (state_r)
        ST_ERROR: begin
          drive_nxt = DRV_OFF;
          state_nxt = ST_WAIT;
          phase_nxt = s1_data_r.now_ms;
        end
        ST_PROCESS: begin
          if (pulse_over || volt_min_low) begin
            drive_nxt = DRV_OFF;
            state_nxt = ST_WAIT;
            phase_nxt = s1_data_r.now_ms;
          end
        end
        ST_WAIT: begin
          if (wait_over) begin
            drive_nxt = DRV_HIZ;
            state_nxt = ST_RELAX;
          end
        end
        ST_RELAX: begin
          if (s1_data_r.driver_fault) state_nxt = ST_ERROR;
        end
      endcase
      // button edge, held until relax with enough supply
      if (s1_data_r.button_level != last_button_r && volt_work_ok &&
          state_nxt == ST_RELAX) begin
        if (s1_data_r.button_level != s1_data_r.hall_open) begin
          drive_nxt = s1_data_r.button_level ? DRV_OPEN : DRV_CLOSE;
          state_nxt = ST_PROCESS;
          phase_nxt = s1_data_r.now_ms;
        end
        last_button_nxt = s1_data_r.button_level;
      end
    end
  end

  // Result fields
  always_comb begin
    result.drive_mode      = drive_nxt;
    result.ctrl_state      = state_nxt;
    result.cmd_accepted    = is_cmd && ((want_open == s1_data_r.hall_open) ||
                                        (volt_work_ok && state_r != ST_ERROR));
    result.position_report = !is_cmd && state_r == ST_WAIT && wait_over;
    result.position_open   = result.position_report && s1_data_r.hall_open;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_time_r   <= PULSE_TIME_RST;
      wait_time_r    <= WAIT_TIME_RST;
      min_voltage_r  <= MIN_VOLTAGE_RST;
      work_voltage_r <= WORK_VOLTAGE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PULSE_TIME:   pulse_time_r   <= cfg_data;
        CFG_WAIT_TIME:    wait_time_r    <= cfg_data;
        CFG_MIN_VOLTAGE:  min_voltage_r  <= cfg_data;
        CFG_WORK_VOLTAGE: work_voltage_r <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      state_r       <= ST_ERROR;
      drive_r       <= DRV_OFF;
      phase_r       <= '0;
      last_button_r <= 1'b0;
    end else begin
      if (!in_stall) s1_valid_r <= in_valid;
      if (out_free) out_valid_r <= s1_valid_r;
      if (s1_fire) begin
        state_r       <= state_nxt;
        drive_r       <= drive_nxt;
        phase_r       <= phase_nxt;
        last_button_r <= last_button_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) s1_data_r <= in_data;
    if (s1_fire) out_data_r <= result;
  end

  `BAPF_ASSERT_NOW(a_process_drives, state_r == ST_PROCESS,
                   drive_r == DRV_OPEN || drive_r == DRV_CLOSE,
                   "pulse state without coil drive")
  `BAPF_ASSERT_NOW(a_relax_hiz, state_r == ST_RELAX, drive_r == DRV_HIZ,
                   "relax state with driver not floating")
  `BAPF_ASSERT_NOW(a_wait_off, state_r == ST_WAIT, drive_r == DRV_OFF,
                   "wait state with coil driven")
  `BAPF_ASSERT_NOW(a_report_state, out_valid_r && out_data_r.position_report,
                   out_data_r.ctrl_state == ST_RELAX || out_data_r.ctrl_state == ST_PROCESS,
                   "position reported outside relax or new pulse")
  `BAPF_ASSERT_NEXT(a_state_hold, !s1_fire, $stable(state_r) && $stable(phase_r),
                    "controller state moved without an item")

endmodule

`default_nettype wire

[verif/bistable_actuator_pulse_fsm_tb.sv]
// Self-checking testbench for the shutter coil controller: directed table, random items, checker.
`default_nettype none

module bistable_actuator_pulse_fsm_tb;
  import bapf_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int DIR_N = 20;
  localparam int PHASES = 5;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int HOLD_AT = 200;
  localparam int HOLD_CYCLES = 150;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    in_item_t  item;
    logic      lit;
    out_item_t res;
  } row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;
  logic                cfg_we = 1'b0;
  logic [1:0]          cfg_index = CFG_PULSE_TIME;
  logic [CFG_BITS-1:0] cfg_data = '0;

  // typed-in expectation travels with the item it belongs to
  logic      cur_lit = 1'b0;
  out_item_t cur_lit_val = '0;

  // controller image
  state_t      m_state;
  drive_t      m_drive;
  logic [31:0] m_phase_start;
  logic        m_last_btn;
  logic [15:0] m_pulse_time, m_wait_time, m_min_volt, m_work_volt;

  out_item_t results_due [$];
  int        errors = 0;
  int        results_seen = 0;
  int        cycles = 0;

  logic [31:0] clock_ms;
  logic        hall_hold, btn_hold;
  int          step_max;
  int          tx_count = 0;
  logic        tx_burst = 1'b0;
  row_t        dir_rows [DIR_N];

  bistable_actuator_pulse_fsm dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic begin_pulse(logic want_open, logic hall, logic [15:0] volt,
                                       logic [31:0] now);
    if (want_open == hall) return 1'b1;
    if (volt < m_work_volt) return 1'b0;
    if (m_state == ST_ERROR) return 1'b0;
    m_drive = want_open ? DRV_OPEN : DRV_CLOSE;
    m_state = ST_PROCESS;
    m_phase_start = now;
    return 1'b1;
  endfunction

  function automatic out_item_t coil_step(in_item_t it);
    out_item_t   r;
    logic [31:0] elapsed;
    r = '0;
    if (it.req_type == REQ_OPEN || it.req_type == REQ_CLOSE) begin
      r.cmd_accepted = begin_pulse(it.req_type == REQ_OPEN, it.hall_open, it.supply_voltage,
                                   it.now_ms);
    end else begin
      elapsed = it.now_ms - m_phase_start;
      case (m_state)
        ST_ERROR: begin
          m_drive = DRV_OFF;
          m_state = ST_WAIT;
          m_phase_start = it.now_ms;
        end
        ST_PROCESS: begin
          if (elapsed > m_pulse_time || it.supply_voltage < m_min_volt) begin
            m_drive = DRV_OFF;
            m_state = ST_WAIT;
            m_phase_start = it.now_ms;
          end
        end
        ST_WAIT: begin
          if (elapsed > m_wait_time) begin
            m_drive = DRV_HIZ;
            m_state = ST_RELAX;
            r.position_report = 1'b1;
            r.position_open = it.hall_open;
          end
        end
        default: begin
          if (it.driver_fault) m_state = ST_ERROR;
        end
      endcase
      if (it.button_level != m_last_btn && it.supply_voltage >= m_work_volt &&
          m_state == ST_RELAX) begin
        if (it.button_level && !it.hall_open)
          void'(begin_pulse(1'b1, it.hall_open, it.supply_voltage, it.now_ms));
        else if (!it.button_level && it.hall_open)
          void'(begin_pulse(1'b0, it.hall_open, it.supply_voltage, it.now_ms));
        m_last_btn = it.button_level;
      end
    end
    r.drive_mode = m_drive;
    r.ctrl_state = m_state;
    return r;
  endfunction

  function automatic void flag_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("bistable_actuator_pulse_fsm_tb: done, errors");
      $finish;
    end
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PULSE_TIME:   m_pulse_time = cfg_data;
          CFG_WAIT_TIME:    m_wait_time = cfg_data;
          CFG_MIN_VOLTAGE:  m_min_volt = cfg_data;
          CFG_WORK_VOLTAGE: m_work_volt = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (results_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected item, expected none, got %h", $time, out_data);
        end else begin
          want = results_due.pop_front();
          if (^out_data === 1'bx) begin
            errors++;
            $display("%0t: unknown bits, expected %h, got %h", $time, want, out_data);
          end else begin
            flag_field("drive_mode", want.drive_mode, out_data.drive_mode);
            flag_field("ctrl_state", want.ctrl_state, out_data.ctrl_state);
            flag_field("cmd_accepted", want.cmd_accepted, out_data.cmd_accepted);
            flag_field("position_report", want.position_report, out_data.position_report);
            flag_field("position_open", want.position_open, out_data.position_open);
          end
        end
      end
      if (in_valid && !in_stall) begin
        want = coil_step(in_data);
        results_due.push_back(cur_lit ? cur_lit_val : want);
      end
    end
  end

  // result side: random stalls, quiet stretches, one long hold-off
  initial begin
    int   n;
    int   rx_count;
    logic rx_burst;
    logic held;
    rx_count = 0;
    rx_burst = 1'b0;
    held = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_count % 60 == 0) rx_burst = ($urandom_range(0, 2) == 0);
      n = rx_burst ? 0 : $urandom_range(0, 17);
      if (!held && results_seen >= HOLD_AT) begin
        n = HOLD_CYCLES;
        held = 1'b1;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      rx_count++;
    end
  end

  task automatic send_item(input in_item_t d, input logic lit, input out_item_t res);
    int gap;
    if (tx_count % 60 == 0) tx_burst = ($urandom_range(0, 2) == 0);
    tx_count++;
    gap = tx_burst ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    cur_lit <= lit;
    cur_lit_val <= res;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_put(input logic [1:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [15:0] pt, input logic [15:0] wt,
                                input logic [15:0] mv, input logic [15:0] wv);
    cfg_put(CFG_PULSE_TIME, pt);
    cfg_put(CFG_WAIT_TIME, wt);
    cfg_put(CFG_MIN_VOLTAGE, mv);
    cfg_put(CFG_WORK_VOLTAGE, wv);
    cfg_we <= 1'b0;
    step_max = ((pt > wt ? int'(pt) : int'(wt)) >> 3) + 3;
  endtask

  function automatic logic [15:0] draw_supply();
    int pick, v;
    pick = $urandom_range(0, 99);
    if (pick < 15) v = $urandom_range(0, 65535);
    else if (pick < 40) v = int'(m_work_volt) + int'($urandom_range(0, 6)) - 3;
    else if (pick < 60) v = int'(m_min_volt) + int'($urandom_range(0, 6)) - 3;
    else v = $urandom_range(int'(m_work_volt), 65535);
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  function automatic in_item_t draw_item();
    in_item_t it;
    int       r;
    r = $urandom_range(0, 99);
    if (r < 62) it.req_type = REQ_POLL;
    else if (r < 66) it.req_type = REQ_UNUSED;
    else if (r < 83) it.req_type = REQ_OPEN;
    else it.req_type = REQ_CLOSE;
    if ($urandom_range(0, 99) < 3) clock_ms = $urandom();
    else clock_ms += $urandom_range(0, step_max);
    if ($urandom_range(0, 3) == 0) hall_hold = ~hall_hold;
    if ($urandom_range(0, 4) == 0) btn_hold = ~btn_hold;
    it.now_ms = clock_ms;
    it.supply_voltage = draw_supply();
    it.hall_open = hall_hold;
    it.driver_fault = ($urandom_range(0, 24) == 0);
    it.button_level = btn_hold;
    return it;
  endfunction

  initial begin
    logic [15:0] pt, wt, mv, wv;
    m_state = ST_ERROR;
    m_drive = DRV_OFF;
    m_phase_start = '0;
    m_last_btn = 1'b0;
    m_pulse_time = PULSE_TIME_RST;
    m_wait_time = WAIT_TIME_RST;
    m_min_volt = MIN_VOLTAGE_RST;
    m_work_volt = WORK_VOLTAGE_RST;
    hall_hold = 1'b0;
    btn_hold = 1'b0;
    step_max = 20;

    dir_rows[0]  = '{'{REQ_OPEN,   32'd0,    16'hFFFF, 1'b0, 1'b0, 1'b0}, 1'b1,
                     '{DRV_OFF, ST_ERROR, 1'b0, 1'b0, 1'b0}};
    dir_rows[1]  = '{'{REQ_CLOSE,  32'd0,    16'd0,    1'b0, 1'b0, 1'b0}, 1'b1,
                     '{DRV_OFF, ST_ERROR, 1'b1, 1'b0, 1'b0}};
    dir_rows[2]  = '{'{REQ_POLL,   32'd1000, 16'd0,    1'b0, 1'b1, 1'b0}, 1'b1,
                     '{DRV_OFF, ST_WAIT, 1'b0, 1'b0, 1'b0}};
    dir_rows[3]  = '{'{REQ_POLL,   32'd1100, 16'd0,    1'b0, 1'b0, 1'b0}, 1'b1,
                     '{DRV_OFF, ST_WAIT, 1'b0, 1'b0, 1'b0}};
    dir_rows[4]  = '{'{REQ_UNUSED, 32'd1101, 16'd0,    1'b1, 1'b0, 1'b0}, 1'b1,
                     '{DRV_HIZ, ST_RELAX, 1'b0, 1'b1, 1'b1}};
    dir_rows[5]  = '{'{REQ_POLL,   32'd1200, 16'd10000, 1'b1, 1'b0, 1'b1}, 1'b1,
                     '{DRV_HIZ, ST_RELAX, 1'b0, 1'b0, 1'b0}};
    dir_rows[6]  = '{'{REQ_POLL,   32'd1250, 16'd9999,  1'b1, 1'b0, 1'b0}, 1'b0, '0};
    dir_rows[7]  = '{'{REQ_POLL,   32'd1300, 16'd10000, 1'b1, 1'b0, 1'b0}, 1'b0, '0};
    dir_rows[8]  = '{'{REQ_POLL,   32'd1350, 16'd8000,  1'b1, 1'b0, 1'b0}, 1'b0, '0};
    dir_rows[9]  = '{'{REQ_POLL,   32'd1351, 16'd9000,  1'b0, 1'b0, 1'b1}, 1'b0, '0};
    dir_rows[10] = '{'{REQ_OPEN,   32'd1400, 16'd10000, 1'b0, 1'b0, 1'b1}, 1'b0, '0};
    dir_rows[11] = '{'{REQ_POLL,   32'd1401, 16'd7999,  1'b0, 1'b0, 1'b1}, 1'b0, '0};
    dir_rows[12] = '{'{REQ_POLL,   32'd1502, 16'd10000, 1'b0, 1'b0, 1'b1}, 1'b0, '0};
    dir_rows[13] = '{'{REQ_CLOSE,  32'd1503, 16'd9999,  1'b1, 1'b0, 1'b1}, 1'b0, '0};
    dir_rows[14] = '{'{REQ_POLL,   32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1}, 1'b0, '0};
    dir_rows[15] = '{'{REQ_POLL,   32'd100,  16'hFFFF, 1'b1, 1'b0, 1'b1}, 1'b0, '0};
    dir_rows[16] = '{'{REQ_POLL,   32'd101,  16'd0,    1'b1, 1'b1, 1'b0}, 1'b0, '0};
    dir_rows[17] = '{'{REQ_CLOSE,  32'd102,  16'hFFFF, 1'b1, 1'b0, 1'b0}, 1'b0, '0};
    dir_rows[18] = '{'{REQ_OPEN,   32'd103,  16'hFFFF, 1'b1, 1'b0, 1'b0}, 1'b0, '0};
    dir_rows[19] = '{'{REQ_POLL,   32'd200,  16'd12000, 1'b1, 1'b0, 1'b0}, 1'b0, '0};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin pt = 16'd50; wt = 16'd100; mv = 16'd8000; wv = 16'd10000; end
        1: begin pt = 16'd0; wt = 16'd0; mv = 16'd0; wv = 16'd0; end
        2: begin pt = 16'hFFFF; wt = 16'hFFFF; mv = 16'hFFFF; wv = 16'hFFFF; end
        3: begin pt = 16'd7; wt = 16'd12; mv = 16'd3000; wv = 16'd5000; end
        default: begin
          pt = $urandom_range(0, 65535);
          wt = $urandom_range(0, 65535);
          mv = $urandom_range(0, 65535);
          wv = $urandom_range(0, 65535);
        end
      endcase
      apply_settings(pt, wt, mv, wv);
      if (p == 0) begin
        for (int i = 0; i < DIR_N; i++)
          send_item(dir_rows[i].item, dir_rows[i].lit, dir_rows[i].res);
        clock_ms = 32'd300;
      end
      // one phase starts close to the time wrap
      if (p == 3) clock_ms = 32'hFFFF_F000;
      for (int i = 0; i < ITEMS_PER_PHASE; i++)
        send_item(draw_item(), 1'b0, '0);
      drain();
    end

    if (errors == 0) begin
      $display("bistable_actuator_pulse_fsm_tb: done, clean");
    end else begin
      $display("bistable_actuator_pulse_fsm_tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
